// ===== design/pcpl_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpl_pkg
// Shared constants, codes and controller/datapath bundles for the per-CPU
// free page list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpl_pkg;

  localparam int CPU_COUNT  = 8;
  localparam int POOL_PAGES = 32768;
  localparam int STEAL_MAX  = 64;
  localparam int PAGE_SIZE  = 4096;

  localparam int ADDR_W     = 32;
  localparam int CPU_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W      = $clog2(POOL_PAGES);
  localparam int TAKE_W     = $clog2(STEAL_MAX + 1);
  localparam int TB_AW      = $clog2(STEAL_MAX);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_BOUND = 1'b1;

  localparam logic [ADDR_W-1:0] LOW_BOUND_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] TOP_BOUND_RESET = 32'h8800_0000;

  localparam logic [1:0] RES_FREE  = 2'd0;
  localparam logic [1:0] RES_OWN   = 2'd1;
  localparam logic [1:0] RES_STEAL = 2'd2;
  localparam logic [1:0] RES_OOM   = 2'd3;

  typedef logic [IDX_W-1:0] page_idx_t;

  typedef struct packed {
    logic      vld;
    page_idx_t idx;
  } link_t;

  typedef struct packed {
    logic       ready;
    logic       load;
    logic       free_do;
    logic       own_rd;
    logic       own_pop;
    logic       scan_init;
    logic       scan_next;
    logic       steal_rd;
    logic       steal_wb;
    logic       push_rd;
    logic       push_wr;
    logic       finish;
    logic [1:0] res;
  } pcpl_cmd_t;

  typedef struct packed {
    logic cpu_bad;
    logic own_valid;
    logic scan_self;
    logic scan_has;
    logic scan_last;
    logic taken_full;
    logic taken_zero;
    logic push_last;
    logic out_busy;
  } pcpl_sts_t;

endpackage

`default_nettype wire

// ===== design/pcpl_req_if.sv =====
// ----------------------------------------------------------------------------
// pcpl_req_if
// Request channel: allocate or free one page on behalf of a CPU.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcpl_req_if;
  import pcpl_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [CPU_W-1:0]  requester;
  logic [ADDR_W-1:0] page_addr;

  modport source (output valid, kind, requester, page_addr, input ready);
  modport sink   (input valid, kind, requester, page_addr, output ready);
endinterface

`default_nettype wire

// ===== design/pcpl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pcpl_rsp_if
// Response channel: granted page, status and count of pages taken.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcpl_rsp_if;
  import pcpl_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_addr;
  logic [STATUS_W-1:0] status;
  logic [TAKE_W-1:0]   taken_count;

  modport source (output valid, granted_addr, status, taken_count, input ready);
  modport sink   (input valid, granted_addr, status, taken_count, output ready);
endinterface

`default_nettype wire

// ===== design/per_cpu_page_free_list_steal.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_steal
// Per-CPU LIFO free page lists linked through a next-link memory; an
// allocate on an empty list takes up to 64 pages from the other CPUs.
//
//   port    dir  handshake      carries
//   req     in   valid/ready    kind, requester, page_addr
//   rsp     out  valid/ready    granted_addr, status, taken_count
//   cfg_*   in   write enable   cfg_index, cfg_data (low_bound, top_bound)
//
// Free checks the address and links the page in; an own-list allocate
// pops the head. Taking scans the other CPUs, relinks each page taken,
// and pushes them onto its own list, paced by the registered link read.
// Reset empties every list; no clearing pass. The result sits in an output
// register; a new request is taken while it waits, and a finished item
// holds in place until that register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module per_cpu_page_free_list_steal (
  input  logic                           clk,
  input  logic                           rst,
  pcpl_req_if.sink                       req,
  pcpl_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [pcpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcpl_pkg::ADDR_W-1:0]    cfg_data
);
  import pcpl_pkg::*;

  pcpl_cmd_t cmd;
  pcpl_sts_t sts;

  assign req.ready = cmd.ready;

  pcpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcpl_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_requester     (req.requester),
    .in_page_addr     (req.page_addr),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_granted_addr (rsp.granted_addr),
    .out_status       (rsp.status),
    .out_taken_count  (rsp.taken_count)
  );

  a_no_finish_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy)
    else $error("result written while output register still full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous one in progress");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STATUS_OK) |-> rsp.granted_addr == '0)
    else $error("address granted with failing status");

  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.taken_count <= TAKE_W'(STEAL_MAX))
    else $error("taken count beyond limit");

endmodule

`default_nettype wire

// ===== design/pcpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcpl_ctrl
// Sequencer for free, own-list pop and the steal / relink walk.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_kind,
  input  pcpl_pkg::pcpl_sts_t sts,
  output pcpl_pkg::pcpl_cmd_t cmd
);
  import pcpl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FREE    = 4'd1;
  localparam logic [3:0] S_ALLOC   = 4'd2;
  localparam logic [3:0] S_OWN     = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_STEAL   = 4'd5;
  localparam logic [3:0] S_PUSH_RD = 4'd6;
  localparam logic [3:0] S_PUSH_WR = 4'd7;
  localparam logic [3:0] S_FAIL    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.res    = RES_FREE;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = (in_kind == KIND_FREE) ? S_FREE : S_ALLOC;
        end
      end
      S_FREE: begin
        if (!sts.out_busy) begin
          cmd.free_do = 1'b1;
          cmd.finish  = 1'b1;
          cmd.res     = RES_FREE;
          state_next  = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (sts.cpu_bad) begin
          state_next = S_FAIL;
        end else if (sts.own_valid) begin
          cmd.own_rd = 1'b1;
          state_next = S_OWN;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_OWN: begin
        if (!sts.out_busy) begin
          cmd.own_pop = 1'b1;
          cmd.finish  = 1'b1;
          cmd.res     = RES_OWN;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.taken_full) begin
          state_next = S_PUSH_RD;
        end else if (sts.scan_self || !sts.scan_has) begin
          if (sts.scan_last) begin
            state_next = sts.taken_zero ? S_FAIL : S_PUSH_RD;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end else begin
          cmd.steal_rd = 1'b1;
          state_next   = S_STEAL;
        end
      end
      S_STEAL: begin
        cmd.steal_wb = 1'b1;
        state_next   = S_SCAN;
      end
      S_PUSH_RD: begin
        cmd.push_rd = 1'b1;
        state_next  = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        if (!sts.push_last) begin
          cmd.push_wr = 1'b1;
          state_next  = S_PUSH_RD;
        end else if (!sts.out_busy) begin
          cmd.push_wr = 1'b1;
          cmd.finish  = 1'b1;
          cmd.res     = RES_STEAL;
          state_next  = S_IDLE;
        end
      end
      S_FAIL: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          cmd.res    = RES_OOM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/pcpl_dp.sv =====
// ----------------------------------------------------------------------------
// pcpl_dp
// Datapath: bound registers, list heads, next-link memory, take buffer,
// walk counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpl_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pcpl_pkg::pcpl_cmd_t               cmd,
  output pcpl_pkg::pcpl_sts_t               sts,
  input  logic [pcpl_pkg::CPU_W-1:0]        in_requester,
  input  logic [pcpl_pkg::ADDR_W-1:0]       in_page_addr,
  input  logic                              cfg_we,
  input  logic [pcpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcpl_pkg::ADDR_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcpl_pkg::ADDR_W-1:0]       out_granted_addr,
  output logic [pcpl_pkg::STATUS_W-1:0]     out_status,
  output logic [pcpl_pkg::TAKE_W-1:0]       out_taken_count
);
  import pcpl_pkg::*;

  logic [ADDR_W-1:0] low_bound;
  logic [ADDR_W-1:0] top_bound;
  logic [PFN_W:0]    base_page;

  logic [CPU_W-1:0]  op_cpu;
  logic [ADDR_W-1:0] op_addr;

  page_idx_t         head_idx [CPU_COUNT];
  logic [CPU_COUNT-1:0] head_vld;

  link_t             link_mem [POOL_PAGES];
  link_t             link_rdata;
  logic              link_we;
  logic              link_re;
  page_idx_t         link_waddr;
  page_idx_t         link_raddr;
  link_t             link_wdata;

  page_idx_t         tb_mem [STEAL_MAX];
  page_idx_t         tb_rdata;

  logic [CPU_W-1:0]  scan_cpu;
  logic [TAKE_W-1:0] taken;
  logic [TAKE_W-1:0] push_k;
  page_idx_t         prev_idx;
  logic              prev_vld;

  logic              cpu_bad;
  logic              aligned;
  logic              ge_low;
  logic              lt_top;
  logic              ge_base;
  logic [PFN_W:0]    pfn_diff;
  logic              in_pool;
  logic              free_ok;
  page_idx_t         free_idx;
  page_idx_t         gidx;
  logic [PFN_W-1:0]  gpfn;

  // Free address check
  always_comb begin
    cpu_bad  = ({1'b0, op_cpu} >= (CPU_W + 1)'(CPU_COUNT));
    aligned  = (op_addr[PAGE_SHIFT-1:0] == '0);
    ge_low   = (op_addr >= low_bound);
    lt_top   = (op_addr < top_bound);
    ge_base  = ({1'b0, op_addr[ADDR_W-1:PAGE_SHIFT]} >= base_page);
    pfn_diff = {1'b0, op_addr[ADDR_W-1:PAGE_SHIFT]} - base_page;
    in_pool  = (pfn_diff[PFN_W:IDX_W] == '0);
    free_idx = pfn_diff[IDX_W-1:0];
    free_ok  = !cpu_bad && aligned && ge_low && lt_top && ge_base && in_pool;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound <= LOW_BOUND_RESET;
      top_bound <= TOP_BOUND_RESET;
      base_page <= {1'b0, LOW_BOUND_RESET[ADDR_W-1:PAGE_SHIFT]};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_BOUND: begin
          low_bound <= cfg_data;
          base_page <= {1'b0, cfg_data[ADDR_W-1:PAGE_SHIFT]}
                       + (PFN_W + 1)'(|cfg_data[PAGE_SHIFT-1:0]);
        end
        REG_TOP_BOUND: begin
          top_bound <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cpu  <= in_requester;
      op_addr <= in_page_addr;
    end
  end

  // Next-link memory
  always_comb begin
    link_we    = (cmd.free_do && free_ok) || cmd.push_wr;
    link_waddr = cmd.push_wr ? tb_rdata : free_idx;
    link_wdata = cmd.push_wr ? link_t'({prev_vld, prev_idx})
                             : link_t'({head_vld[op_cpu], head_idx[op_cpu]});
    link_re    = cmd.own_rd || cmd.steal_rd;
    link_raddr = cmd.steal_rd ? head_idx[scan_cpu] : head_idx[op_cpu];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  // Take buffer
  always_ff @(posedge clk) begin
    if (cmd.steal_rd) begin
      tb_mem[taken[TB_AW-1:0]] <= head_idx[scan_cpu];
    end
    if (cmd.push_rd) begin
      tb_rdata <= tb_mem[push_k[TB_AW-1:0]];
    end
  end

  // List heads
  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
    end else if (cmd.free_do && free_ok) begin
      head_idx[op_cpu] <= free_idx;
      head_vld[op_cpu] <= 1'b1;
    end else if (cmd.own_pop) begin
      head_idx[op_cpu] <= link_rdata.idx;
      head_vld[op_cpu] <= link_rdata.vld;
    end else if (cmd.steal_wb) begin
      head_idx[scan_cpu] <= link_rdata.idx;
      head_vld[scan_cpu] <= link_rdata.vld;
    end else if (cmd.push_wr && sts.push_last) begin
      head_idx[op_cpu] <= prev_idx;
      head_vld[op_cpu] <= prev_vld;
    end
  end

  // Walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cpu <= '0;
      taken    <= '0;
      push_k   <= '0;
      prev_vld <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        scan_cpu <= '0;
        taken    <= '0;
        push_k   <= '0;
        prev_vld <= 1'b0;
      end
      if (cmd.scan_next) begin
        scan_cpu <= scan_cpu + CPU_W'(1);
      end
      if (cmd.steal_rd) begin
        taken <= taken + TAKE_W'(1);
      end
      if (cmd.push_rd) begin
        push_k <= push_k + TAKE_W'(1);
      end
      if (cmd.push_wr) begin
        prev_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      prev_idx <= tb_rdata;
    end
  end

  // Result register
  always_comb begin
    gidx = (cmd.res == RES_STEAL) ? tb_rdata : head_idx[op_cpu];
    gpfn = base_page[PFN_W-1:0] + PFN_W'(gidx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.res)
        RES_FREE: begin
          out_granted_addr <= '0;
          out_status       <= free_ok ? STATUS_OK : STATUS_BAD_FREE;
          out_taken_count  <= '0;
        end
        RES_OWN: begin
          out_granted_addr <= {gpfn, PAGE_SHIFT'(0)};
          out_status       <= STATUS_OK;
          out_taken_count  <= '0;
        end
        RES_STEAL: begin
          out_granted_addr <= {gpfn, PAGE_SHIFT'(0)};
          out_status       <= STATUS_OK;
          out_taken_count  <= taken;
        end
        default: begin
          out_granted_addr <= '0;
          out_status       <= STATUS_OOM;
          out_taken_count  <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.cpu_bad    = cpu_bad;
    sts.own_valid  = head_vld[op_cpu];
    sts.scan_self  = (scan_cpu == op_cpu);
    sts.scan_has   = head_vld[scan_cpu];
    sts.scan_last  = (scan_cpu == CPU_W'(CPU_COUNT - 1));
    sts.taken_full = (taken == TAKE_W'(STEAL_MAX));
    sts.taken_zero = (taken == '0);
    sts.push_last  = (push_k == taken);
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// ===== tb/sv/per_cpu_page_free_list_steal_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_steal_test
// Self-checking bench for the per-CPU free page list allocator. A driver feeds
// allocate and free items from a backlog. A shadow of the per-CPU lists and
// the next-link memory computes each response, and a monitor checks every
// response against it. The run goes through several bound settings, from
// a full 32-bit window to windows that reject every free.
// ----------------------------------------------------------------------------

module per_cpu_page_free_list_steal_test;
  import pcpl_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [CPU_W-1:0]  requester;
    logic [ADDR_W-1:0] page_addr;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_addr;
    logic [STATUS_W-1:0] status;
    logic [TAKE_W-1:0]   taken_count;
  } page_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  pcpl_req_if req_bus ();
  pcpl_rsp_if rsp_bus ();

  per_cpu_page_free_list_steal dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the allocator
  logic [ADDR_W-1:0] bound_lo = LOW_BOUND_RESET;
  logic [ADDR_W-1:0] bound_hi = TOP_BOUND_RESET;
  page_idx_t         top_idx [CPU_COUNT];
  bit                top_vld [CPU_COUNT];
  page_idx_t         chain_idx [POOL_PAGES];
  bit                chain_vld [POOL_PAGES];
  page_idx_t         haul [STEAL_MAX];

  page_req_t backlog [$];
  page_rsp_t due_rsps [$];
  page_idx_t handed_pages [$];
  bit        page_seen [POOL_PAGES];

  page_req_t on_bus;
  page_rsp_t want;
  bit        gaps_on;
  int        mismatch_count;
  int        n_items, n_grants, n_taking, n_oom, n_bad_free, most_taken;

  function automatic logic [ADDR_W:0] page_base_of(logic [ADDR_W-1:0] lo);
    return ({1'b0, lo} + 33'(PAGE_SIZE - 1)) & ~33'(PAGE_SIZE - 1);
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr_of(page_idx_t idx);
    logic [ADDR_W:0] a;
    a = page_base_of(bound_lo) + (33'(idx) << PAGE_SHIFT);
    return a[ADDR_W-1:0];
  endfunction

  function automatic void stack_page(int cpu, page_idx_t idx);
    chain_idx[idx] = top_idx[cpu];
    chain_vld[idx] = top_vld[cpu];
    top_idx[cpu]   = idx;
    top_vld[cpu]   = 1'b1;
  endfunction

  function automatic page_idx_t unstack_page(int cpu);
    page_idx_t idx;
    idx          = top_idx[cpu];
    top_idx[cpu] = chain_idx[idx];
    top_vld[cpu] = chain_vld[idx];
    return idx;
  endfunction

  task automatic model_page_request(input page_req_t it);
    page_rsp_t       res;
    logic [ADDR_W:0] base, addr, g;
    page_idx_t       idx;
    int              taken, cpu;
    bit              have;
    res   = '0;
    taken = 0;
    have  = 1'b0;
    idx   = '0;
    cpu   = it.requester;
    base  = page_base_of(bound_lo);
    addr  = {1'b0, it.page_addr};
    n_items++;
    if (it.kind == KIND_FREE) begin
      if (addr[PAGE_SHIFT-1:0] != '0 || it.page_addr < bound_lo ||
          it.page_addr >= bound_hi || addr < base ||
          ((addr - base) >> PAGE_SHIFT) >= POOL_PAGES) begin
        res.status = STATUS_BAD_FREE;
        n_bad_free++;
      end else begin
        stack_page(cpu, page_idx_t'((addr - base) >> PAGE_SHIFT));
      end
    end else begin
      if (top_vld[cpu]) begin
        idx  = unstack_page(cpu);
        have = 1'b1;
      end else begin
        for (int c = 0; c < CPU_COUNT; c++) begin
          if (c != cpu) begin
            while (top_vld[c] && taken < STEAL_MAX) begin
              haul[taken] = unstack_page(c);
              taken++;
            end
          end
        end
        if (taken > 0) begin
          for (int k = 0; k < taken; k++) stack_page(cpu, haul[k]);
          idx  = unstack_page(cpu);
          have = 1'b1;
          n_taking++;
          if (taken > most_taken) most_taken = taken;
        end
      end
      if (have) begin
        g = base + (33'(idx) << PAGE_SHIFT);
        res.granted_addr = g[ADDR_W-1:0];
        handed_pages.push_back(idx);
        n_grants++;
      end else begin
        res.status = STATUS_OOM;
        n_oom++;
      end
    end
    res.taken_count = TAKE_W'(taken);
    due_rsps.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatch_count < 20)
      $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) model_page_request(on_bus);
      if (!req_bus.valid || req_bus.ready) begin
        if (backlog.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 6)) begin
          on_bus = backlog.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.kind      <= on_bus.kind;
          req_bus.requester <= on_bus.requester;
          req_bus.page_addr <= on_bus.page_addr;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 6);
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (due_rsps.size() == 0) begin
          report_mismatch("unexpected item", rsp_bus.granted_addr, '0);
        end else begin
          want = due_rsps.pop_front();
          if (rsp_bus.granted_addr !== want.granted_addr)
            report_mismatch("granted_addr", rsp_bus.granted_addr, want.granted_addr);
          if (rsp_bus.status !== want.status)
            report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
          if (rsp_bus.taken_count !== want.taken_count)
            report_mismatch("taken_count", 32'(rsp_bus.taken_count), 32'(want.taken_count));
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (backlog.size() != 0 || req_bus.valid || due_rsps.size() != 0);
  endtask

  task automatic set_bounds(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOW_BOUND;
    cfg_data  <= lo;
    bound_lo   = lo;
    @(posedge clk);
    cfg_index <= REG_TOP_BOUND;
    cfg_data  <= hi;
    bound_hi   = hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_item(input logic kind, input int cpu, input logic [ADDR_W-1:0] addr);
    page_req_t it;
    it.kind      = kind;
    it.requester = CPU_W'(cpu);
    it.page_addr = addr;
    backlog.push_back(it);
  endtask

  // a page index never freed before that falls inside the current window
  function automatic bit pick_fresh(output page_idx_t idx);
    logic [ADDR_W:0] base;
    int              span;
    idx  = '0;
    base = page_base_of(bound_lo);
    if ({1'b0, bound_hi} <= base) return 1'b0;
    span = ({1'b0, bound_hi} - base) >> PAGE_SHIFT;
    if (span > POOL_PAGES) span = POOL_PAGES;
    if (span == 0) return 1'b0;
    for (int t = 0; t < 8; t++) begin
      idx = page_idx_t'($urandom_range(0, span - 1));
      if (!page_seen[idx]) begin
        page_seen[idx] = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic queue_random_item(input int alloc_pct, input bit dup);
    page_req_t it;
    page_idx_t idx;
    int        r, k;
    it.page_addr = $urandom();
    it.requester = CPU_W'($urandom_range(0, CPU_COUNT - 1));
    if ($urandom_range(0, 99) < alloc_pct) begin
      it.kind = KIND_ALLOC;
      if ($urandom_range(0, 9) < 7) it.requester = CPU_W'($urandom_range(4, 7));
    end else begin
      it.kind = KIND_FREE;
      if ($urandom_range(0, 9) < 7) it.requester = CPU_W'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 45 && handed_pages.size() != 0) begin
        k = $urandom_range(0, handed_pages.size() - 1);
        it.page_addr = page_addr_of(handed_pages[k]);
        handed_pages.delete(k);
      end else if (r < 85 && pick_fresh(idx)) begin
        it.page_addr = page_addr_of(idx);
      end else if (dup && r < 93) begin
        it.page_addr = page_addr_of(page_idx_t'($urandom_range(0, 511)));
      end else if (dup) begin
        it.page_addr = $urandom() & ~32'(PAGE_SIZE - 1);
      end
    end
    backlog.push_back(it);
  endtask

  task automatic run_random(input int n, input int alloc_pct, input bit dup);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      while (backlog.size() >= 2) @(negedge clk);
      queue_random_item(alloc_pct, dup);
    end
  endtask

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    req_bus.valid     = 1'b0;
    req_bus.kind      = KIND_ALLOC;
    req_bus.requester = '0;
    req_bus.page_addr = '0;
    rsp_bus.ready     = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_LOW_BOUND;
    cfg_data          = '0;
    gaps_on           = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    page_seen[0] = 1'b1;
    page_seen[1] = 1'b1;
    page_seen[2] = 1'b1;
    page_seen[3] = 1'b1;
    page_seen[POOL_PAGES-1] = 1'b1;
    push_item(KIND_ALLOC, 0, 32'h0000_0000);
    push_item(KIND_FREE,  0, 32'h8000_0004);
    push_item(KIND_FREE,  1, 32'h7FFF_F000);
    push_item(KIND_FREE,  2, 32'h8800_0000);
    push_item(KIND_FREE,  3, 32'hFFFF_FFFF);
    push_item(KIND_FREE,  4, 32'h0000_0000);
    push_item(KIND_FREE,  7, 32'h87FF_F000);
    push_item(KIND_FREE,  0, 32'h8000_0000);
    push_item(KIND_FREE,  0, 32'h8000_1000);
    push_item(KIND_ALLOC, 0, 32'h0000_0000);
    push_item(KIND_FREE,  2, 32'h8000_2000);
    push_item(KIND_FREE,  5, 32'h8000_3000);
    push_item(KIND_ALLOC, 6, 32'h0000_0000);
    push_item(KIND_ALLOC, 6, 32'hFFFF_FFFF);
    push_item(KIND_ALLOC, 1, 32'h5555_AAAA);
    run_random(200, 35, 1'b0);

    gaps_on = 1'b0;
    set_bounds(32'h0000_0000, 32'hFFFF_FFFF);
    push_item(KIND_FREE, 1, 32'h0800_0000);
    push_item(KIND_FREE, 2, 32'hFFFF_F000);
    run_random(250, 40, 1'b0);

    gaps_on = 1'b1;
    set_bounds(32'hFFFF_F001, 32'hFFFF_FFFF);
    run_random(60, 70, 1'b0);
    set_bounds(32'h8000_0001, 32'h8010_0000);
    run_random(200, 40, 1'b0);
    set_bounds(32'h2000_0000, 32'h0000_0000);
    run_random(120, 80, 1'b0);
    set_bounds(32'h4000_0000, 32'h4800_0000);
    run_random(320, 40, 1'b1);

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Ran %0d items over six bound windows: %0d grants, %0d of them by taking pages,",
             n_items, n_grants, n_taking);
    $display("  %0d out of memory, %0d rejected frees, at most %0d pages taken at once.",
             n_oom, n_bad_free, most_taken);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pcpl_pkg.sv
design/pcpl_req_if.sv
design/pcpl_rsp_if.sv
design/pcpl_ctrl.sv
design/pcpl_dp.sv
design/per_cpu_page_free_list_steal.sv
tb/sv/per_cpu_page_free_list_steal_test.sv
